// ----- rtl/csl_pkg.sv -----
// package for the c subset lexer: token kinds, recogniser state codes and tables
// used by the lexer core and its step logic; no dependencies
package csl_pkg;

    localparam int POS_BITS_DEF = 16;
    localparam int LEN_BITS     = 16;
    localparam int KIND_BITS    = 6;
    localparam int REC_BITS     = 7;

    localparam logic [KIND_BITS-1:0] NO_KIND = 6'd63;
    localparam logic [KIND_BITS-1:0] K_EQEQ  = 6'd17;
    localparam logic [KIND_BITS-1:0] K_NEQ   = 6'd18;
    localparam logic [KIND_BITS-1:0] K_KW0   = 6'd25;
    localparam logic [KIND_BITS-1:0] K_IDENT = 6'd38;
    localparam logic [KIND_BITS-1:0] K_INT   = 6'd39;

    localparam logic [REC_BITS-1:0] S_START = 7'd0;
    localparam logic [REC_BITS-1:0] S_DEAD  = 7'd1;
    localparam logic [REC_BITS-1:0] S_IDENT = 7'd2;
    localparam logic [REC_BITS-1:0] S_INT   = 7'd3;
    localparam logic [REC_BITS-1:0] S_AMP   = 7'd4;
    localparam logic [REC_BITS-1:0] S_AMP2  = 7'd5;
    localparam logic [REC_BITS-1:0] S_BAR   = 7'd6;
    localparam logic [REC_BITS-1:0] S_BAR2  = 7'd7;
    localparam logic [REC_BITS-1:0] S_LT    = 7'd8;
    localparam logic [REC_BITS-1:0] S_LE    = 7'd9;
    localparam logic [REC_BITS-1:0] S_GT    = 7'd10;
    localparam logic [REC_BITS-1:0] S_GE    = 7'd11;
    localparam logic [REC_BITS-1:0] S_EQ    = 7'd12;
    localparam logic [REC_BITS-1:0] S_KW    = 7'd16;
    localparam int N_KW = 10;

    // one token slot
    typedef struct packed {
        logic                  valid;
        logic [KIND_BITS-1:0]  kind;
        logic [31:0]           start;
        logic [LEN_BITS-1:0]   len;
    } tok_t;

    function automatic logic [63:0] kw_text(input int k);
        case (k)
            0: kw_text = "int";
            1: kw_text = "struct";
            2: kw_text = "return";
            3: kw_text = "if";
            4: kw_text = "for";
            5: kw_text = "while";
            6: kw_text = "do";
            7: kw_text = "break";
            8: kw_text = "continue";
            default: kw_text = "else";
        endcase
    endfunction

    function automatic logic [3:0] kw_len(input int k);
        case (k)
            0: kw_len = 4'd3;
            1: kw_len = 4'd6;
            2: kw_len = 4'd6;
            3: kw_len = 4'd2;
            4: kw_len = 4'd3;
            5: kw_len = 4'd5;
            6: kw_len = 4'd2;
            7: kw_len = 4'd5;
            8: kw_len = 4'd8;
            default: kw_len = 4'd4;
        endcase
    endfunction

    // character i (from 0) of keyword k
    function automatic logic [7:0] kw_char(input int k, input int i);
        logic [63:0] t;
        logic [3:0]  n;
        t = kw_text(k);
        n = kw_len(k);
        if (i >= int'(n))
            kw_char = 8'd0;
        else
            kw_char = t[8*(int'(n)-1-i) +: 8];
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = c >= "0" && c <= "9";
    endfunction

    function automatic logic is_wordc(input logic [7:0] c);
        is_wordc = is_letter(c) || is_digit(c) || c == "_";
    endfunction

    function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] c);
        case (c)
            "{": single_kind = 6'd0;
            "}": single_kind = 6'd1;
            "(": single_kind = 6'd2;
            "[": single_kind = 6'd3;
            ")": single_kind = 6'd4;
            "]": single_kind = 6'd5;
            ";": single_kind = 6'd6;
            "-": single_kind = 6'd7;
            "+": single_kind = 6'd8;
            "*": single_kind = 6'd9;
            "%": single_kind = 6'd10;
            "/": single_kind = 6'd11;
            "~": single_kind = 6'd12;
            "!": single_kind = 6'd24;
            ":": single_kind = 6'd35;
            ",": single_kind = 6'd36;
            "?": single_kind = 6'd37;
            default: single_kind = NO_KIND;
        endcase
    endfunction

    function automatic logic [REC_BITS-1:0] rec_next(input logic [REC_BITS-1:0] s,
                                                      input logic [7:0] c);
        logic [REC_BITS-1:0] r;
        logic                found;
        int                  k;
        int                  len;
        int                  i;
        logic                pre;
        r = S_DEAD;
        found = 1'b0;
        if (s == S_START) begin
            if (is_letter(c)) begin
                r = S_IDENT;
                for (int kk = 0; kk < N_KW; kk++) begin
                    if (!found && kw_char(kk, 0) == c) begin
                        r = REC_BITS'(int'(S_KW) + kk * 8);
                        found = 1'b1;
                    end
                end
            end else if (is_digit(c)) r = S_INT;
            else if (c == "&") r = S_AMP;
            else if (c == "|") r = S_BAR;
            else if (c == "<") r = S_LT;
            else if (c == ">") r = S_GT;
            else if (c == "=") r = S_EQ;
        end else if (s >= S_KW && s < REC_BITS'(int'(S_KW) + N_KW * 8)) begin
            k = int'(s - S_KW) / 8;
            len = int'(s - S_KW) % 8 + 1;
            r = is_wordc(c) ? S_IDENT : S_DEAD;
            for (int kk = 0; kk < N_KW; kk++) begin
                pre = 1'b1;
                for (i = 0; i < 8; i++)
                    if (i < len && kw_char(kk, i) != kw_char(k, i)) pre = 1'b0;
                if (!found && int'(kw_len(kk)) > len && pre && kw_char(kk, len) == c) begin
                    r = REC_BITS'(int'(S_KW) + kk * 8 + len);
                    found = 1'b1;
                end
            end
        end else begin
            case (s)
                S_IDENT: r = is_wordc(c) ? S_IDENT : S_DEAD;
                S_INT:   r = is_digit(c) ? S_INT : S_DEAD;
                S_AMP:   r = (c == "&") ? S_AMP2 : S_DEAD;
                S_BAR:   r = (c == "|") ? S_BAR2 : S_DEAD;
                S_LT:    r = (c == "=") ? S_LE : S_DEAD;
                S_GT:    r = (c == "=") ? S_GE : S_DEAD;
                default: r = S_DEAD;
            endcase
        end
        rec_next = r;
    endfunction

    function automatic logic [KIND_BITS-1:0] rec_kind(input logic [REC_BITS-1:0] s);
        int k;
        int len;
        if (s >= S_KW && s < REC_BITS'(int'(S_KW) + N_KW * 8)) begin
            k = int'(s - S_KW) / 8;
            len = int'(s - S_KW) % 8 + 1;
            rec_kind = (len == int'(kw_len(k))) ? KIND_BITS'(int'(K_KW0) + k) : K_IDENT;
        end else begin
            case (s)
                S_IDENT: rec_kind = K_IDENT;
                S_INT:   rec_kind = K_INT;
                S_AMP:   rec_kind = 6'd15;
                S_AMP2:  rec_kind = 6'd13;
                S_BAR:   rec_kind = 6'd16;
                S_BAR2:  rec_kind = 6'd14;
                S_LT:    rec_kind = 6'd20;
                S_LE:    rec_kind = 6'd19;
                S_GT:    rec_kind = 6'd22;
                S_GE:    rec_kind = 6'd21;
                S_EQ:    rec_kind = 6'd23;
                default: rec_kind = NO_KIND;
            endcase
        end
    endfunction

endpackage

// ----- rtl/csl_step.sv -----
// one lexer step: held byte with lookahead, then final byte and word close
// depends on csl_pkg
module csl_step
    import csl_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic [7:0]          held_char,
    input  logic                held_valid,
    input  logic [POS_BITS-1:0] held_pos,
    input  logic                word_open,
    input  logic [POS_BITS-1:0] word_start,
    input  logic [LEN_BITS-1:0] word_len,
    input  logic [REC_BITS-1:0] rec_state,
    input  logic [7:0]          ch,
    input  logic                final_char,
    input  logic [POS_BITS-1:0] pos,
    output tok_t                tok [4],
    output logic                n_held_valid,
    output logic                n_word_open,
    output logic [POS_BITS-1:0] n_word_start,
    output logic [LEN_BITS-1:0] n_word_len,
    output logic [REC_BITS-1:0] n_rec_state,
    output logic                len_sat
);

    // per byte slot: word extend or close plus one token
    always_comb
    begin
        logic                pair;
        logic [KIND_BITS-1:0] sk;
        logic                wo;
        logic [POS_BITS-1:0] ws;
        logic [LEN_BITS-1:0] wl;
        logic [REC_BITS-1:0] rs;
        logic                have_new;
        logic [7:0]          c;
        logic [POS_BITS-1:0] p;
        logic                use_c;
        logic                nxt;
        wo = word_open;
        ws = word_start;
        wl = word_len;
        rs = rec_state;
        len_sat = 1'b0;
        have_new = 1'b1;
        for (int t = 0; t < 4; t++)
        begin
            tok[t].valid = 1'b0;
            tok[t].kind = NO_KIND;
            tok[t].start = '0;
            tok[t].len = '0;
        end
        // slots 0/1: held byte, 2/3: final byte; the final word close reuses slot 2
        for (int s = 0; s < 2; s++)
        begin
            use_c = (s == 0) ? held_valid : (final_char && have_new);
            c = (s == 0) ? held_char : ch;
            p = (s == 0) ? held_pos : pos;
            nxt = (s == 0);
            pair = nxt && ((c == "=" && ch == "=") || (c == "!" && ch == "=") ||
                           (c == "+" && ch == "+") || (c == "-" && ch == "-"));
            sk = single_kind(c);
            if (use_c)
            begin
                if (c != " " && c != 8'h0a && sk == NO_KIND && !pair)
                begin
                    if (!wo)
                    begin
                        wo = 1'b1;
                        ws = p;
                        wl = LEN_BITS'(1);
                        rs = S_START;
                    end
                    else if (wl == '1)
                        len_sat = 1'b1;
                    else
                        wl = wl + 1'b1;
                    rs = rec_next(rs, c);
                end
                else
                begin
                    if (wo)
                    begin
                        tok[2*s].valid = rec_kind(rs) != NO_KIND;
                        tok[2*s].kind = rec_kind(rs);
                        tok[2*s].start = 32'(ws);
                        tok[2*s].len = wl;
                    end
                    wo = 1'b0;
                    ws = '0;
                    wl = '0;
                    rs = S_START;
                    if (pair)
                    begin
                        have_new = 1'b0;
                        if (c == "=" || c == "!")
                        begin
                            tok[2*s+1].valid = 1'b1;
                            tok[2*s+1].kind = (c == "=") ? K_EQEQ : K_NEQ;
                            tok[2*s+1].start = 32'(p);
                            tok[2*s+1].len = LEN_BITS'(2);
                        end
                    end
                    else if (sk != NO_KIND)
                    begin
                        tok[2*s+1].valid = 1'b1;
                        tok[2*s+1].kind = sk;
                        tok[2*s+1].start = 32'(p);
                        tok[2*s+1].len = LEN_BITS'(1);
                    end
                end
            end
        end
        // final close: slot 2 of the final byte holds the close token of slot 1 only
        // if that close did not fire, so reuse a free slot
        if (final_char && wo)
        begin
            if (!tok[2].valid)
            begin
                tok[2].valid = rec_kind(rs) != NO_KIND;
                tok[2].kind = rec_kind(rs);
                tok[2].start = 32'(ws);
                tok[2].len = wl;
            end
        end
        if (final_char)
        begin
            wo = 1'b0;
            ws = '0;
            wl = '0;
            rs = S_START;
        end
        n_held_valid = have_new && !final_char;
        n_word_open = wo;
        n_word_start = ws;
        n_word_len = wl;
        n_rec_state = rs;
    end

endmodule

// ----- rtl/csl_out_queue.sv -----
// output queue: holds up to four tokens from one step and sends them one a cycle while m_tready is high
// depends on csl_pkg
module csl_out_queue
    import csl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  tok_t       tok [4],
    input  logic       clip_in,
    output logic       busy,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [KIND_BITS+16+LEN_BITS-1:0] m_payload,
    output logic       m_last,
    output logic       m_clip
);

    tok_t       slot_reg [4];
    logic [3:0] pend_reg;
    logic       clip_reg;
    logic [1:0] idx;
    logic [3:0] rest;
    logic [15:0] st;

    always_comb
    begin
        idx = 2'd0;
        for (int i = 3; i >= 0; i--)
            if (pend_reg[i]) idx = 2'(i);
        rest = pend_reg;
        rest[idx] = 1'b0;
        st = (slot_reg[idx].start > 32'hFFFF) ? 16'hFFFF : slot_reg[idx].start[15:0];
    end

    assign m_tvalid = |pend_reg;
    assign busy = m_tvalid && !(m_tready && rest == 4'd0);
    assign m_last = rest == 4'd0;
    assign m_clip = clip_reg || (slot_reg[idx].start > 32'hFFFF);
    assign m_payload = {slot_reg[idx].len, st, slot_reg[idx].kind};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else if (load)
        begin
            for (int i = 0; i < 4; i++)
                pend_reg[i] <= tok[i].valid;
        end
        else if (m_tvalid && m_tready)
            pend_reg <= rest;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < 4; i++)
                slot_reg[i] <= tok[i];
            clip_reg <= clip_in;
        end
    end

endmodule

// ----- rtl/c_subset_lexer_core.sv -----
// top level of the c subset lexer: state registers, step logic and output queue
// depends on csl_pkg, csl_step, csl_out_queue
//
// usage
//   s_axis carries one program byte per transaction: tdata = ch, tlast = final_char
//   m_axis carries one token per transaction: kind, start_pos, span_len in tdata,
//   tlast = run_end (last token caused by one input byte), tuser = clipped
//   one byte is taken per cycle while the output queue can absorb its tokens;
//   each byte may cause up to four tokens, sent one per cycle while m_tready is high,
//   so the input stalls while the extra tokens of a byte are sent
//   tokens caused by a byte appear in the cycle after it is accepted
//   a byte is held back one step as pair lookahead; the final byte flushes it
//   at reset the lexer state and the queue's pending flags are cleared and the recogniser sits in its start state
//   when the receiver stalls, the queue holds and s_tready drops until it drains
module c_subset_lexer_core
    import csl_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch
    input  logic        s_tlast,   // final_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // kind[5:0], start_pos[21:6], span_len[37:22], zero pad
    output logic        m_tlast,   // run_end
    output logic        m_tuser    // clipped
);

    logic [7:0]          held_char_reg;
    logic                held_valid_reg;
    logic [POS_BITS-1:0] held_pos_reg;
    logic                word_open_reg;
    logic [POS_BITS-1:0] word_start_reg;
    logic [LEN_BITS-1:0] word_len_reg;
    logic [REC_BITS-1:0] rec_state_reg;
    logic [POS_BITS-1:0] char_pos_reg;
    logic                ovf_reg;

    tok_t                tok [4];
    logic                n_held_valid;
    logic                n_word_open;
    logic [POS_BITS-1:0] n_word_start;
    logic [LEN_BITS-1:0] n_word_len;
    logic [REC_BITS-1:0] n_rec_state;
    logic                len_sat;
    logic                busy;
    logic                acc;
    logic                pos_sat;
    logic                ovf_next;
    logic [KIND_BITS+16+LEN_BITS-1:0] payload;

    assign s_tready = !busy;
    assign acc = s_tvalid && s_tready;
    assign pos_sat = char_pos_reg == '1;
    assign ovf_next = ovf_reg || pos_sat || len_sat;

    csl_step #(.POS_BITS(POS_BITS)) u_step (
        .held_char(held_char_reg), .held_valid(held_valid_reg), .held_pos(held_pos_reg),
        .word_open(word_open_reg), .word_start(word_start_reg), .word_len(word_len_reg),
        .rec_state(rec_state_reg), .ch(s_tdata), .final_char(s_tlast),
        .pos(char_pos_reg), .tok(tok), .n_held_valid(n_held_valid),
        .n_word_open(n_word_open), .n_word_start(n_word_start), .n_word_len(n_word_len),
        .n_rec_state(n_rec_state), .len_sat(len_sat)
    );

    csl_out_queue u_queue (
        .clk(clk), .rst_n(rst_n), .load(acc), .tok(tok), .clip_in(ovf_next),
        .busy(busy), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_payload(payload),
        .m_last(m_tlast), .m_clip(m_tuser)
    );

    assign m_tdata = {2'b00, payload};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_char_reg <= '0;
            held_valid_reg <= 1'b0;
            held_pos_reg <= '0;
            word_open_reg <= 1'b0;
            word_start_reg <= '0;
            word_len_reg <= '0;
            rec_state_reg <= S_START;
            char_pos_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (acc)
        begin
            held_char_reg <= s_tdata;
            held_pos_reg <= char_pos_reg;
            held_valid_reg <= n_held_valid;
            word_open_reg <= n_word_open;
            word_start_reg <= n_word_start;
            word_len_reg <= n_word_len;
            rec_state_reg <= n_rec_state;
            if (s_tlast)
            begin
                char_pos_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else
            begin
                char_pos_reg <= pos_sat ? char_pos_reg : char_pos_reg + 1'b1;
                ovf_reg <= ovf_next;
            end
        end
    end

endmodule

// ----- rtl/csl_checker.sv -----
// port-level checker for the c subset lexer core, bound to the top level
// depends on c_subset_lexer_core ports only
module csl_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[5:0] <= 6'd39)
        else $error("bad token kind");

    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[37:22] != 16'd0)
        else $error("zero token length");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // tokens of one byte follow each other without a gap
    a_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("token run broken");

endmodule

bind c_subset_lexer_core csl_checker u_csl_checker (
    .clk(clk), .rst_n(rst_n), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
